/* rtl/hsv_pkg.sv */
package hsv_pkg;

  localparam int HUE_W = 10;
  localparam int PCT_W = 7;
  localparam int SECT_W = 3;
  localparam int WT_W = 6;
  localparam int C_W = 14;
  localparam int SC_W = 20;
  localparam int T_W = 18;
  localparam int RECIP_W = 19;
  localparam int PROD_W = T_W + RECIP_W;
  localparam int CH_W = 8;
  localparam int NUM_CH = 3;

  localparam int HUE_MAX = 360;
  localparam int PCT_MAX = 100;
  localparam int SECTOR_DEG = 60;

  // floor(255 * y / 600000) = floor(((17 * y) >> 6) / 625), and the division by 625
  // is a multiplication by ceil(2^28 / 625) followed by a shift by 28.
  localparam int SCALE_MUL = 17;
  localparam int SCALE_PRE_SHIFT = 6;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(429497);

  localparam logic [SECT_W-1:0] SECT_RY = 3'd0;
  localparam logic [SECT_W-1:0] SECT_YG = 3'd1;
  localparam logic [SECT_W-1:0] SECT_GC = 3'd2;
  localparam logic [SECT_W-1:0] SECT_CB = 3'd3;
  localparam logic [SECT_W-1:0] SECT_BM = 3'd4;
  localparam logic [SECT_W-1:0] SECT_MR = 3'd5;

  localparam logic [1:0] PICK_ZERO = 2'd0;
  localparam logic [1:0] PICK_C = 2'd1;
  localparam logic [1:0] PICK_X = 2'd2;

  localparam int CH_RED = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE = 2;

  typedef logic [NUM_CH-1:0][1:0] pick_set_t;

  typedef struct packed {
    logic              in_range;
    logic [SECT_W-1:0] sector;
    logic [WT_W-1:0]   weight;
    logic [PCT_W-1:0]  sat;
    logic [PCT_W-1:0]  val;
  } dec_t;

  typedef struct packed {
    logic            in_range;
    pick_set_t       picks;
    logic [SC_W-1:0] c60;
    logic [SC_W-1:0] x60;
    logic [SC_W-1:0] m60;
  } mix_t;

  function automatic pick_set_t picks_for(input logic [SECT_W-1:0] sector);
    pick_set_t p;
    p = '{default: PICK_ZERO};
    case (sector)
      SECT_RY: begin
        p[CH_RED] = PICK_C;
        p[CH_GREEN] = PICK_X;
      end
      SECT_YG: begin
        p[CH_RED] = PICK_X;
        p[CH_GREEN] = PICK_C;
      end
      SECT_GC: begin
        p[CH_GREEN] = PICK_C;
        p[CH_BLUE] = PICK_X;
      end
      SECT_CB: begin
        p[CH_GREEN] = PICK_X;
        p[CH_BLUE] = PICK_C;
      end
      SECT_BM: begin
        p[CH_RED] = PICK_X;
        p[CH_BLUE] = PICK_C;
      end
      default: begin
        p[CH_RED] = PICK_C;
        p[CH_BLUE] = PICK_X;
      end
    endcase
    return p;
  endfunction

endpackage

/* rtl/hsv_to_rgb_core.sv */
// HSV to RGB pixel converter. Each request carries a hue in whole degrees (0 to 360,
// two's complement) and saturation and value in percent (0 to 100). The result gives
// 8-bit red, green and blue and an in-range flag on tuser. Each channel is exactly
// floor(255 * (channel + m) / 10000), where chroma S * V and the offset 100 * V - C
// are counted in ten-thousandths. Any operand out of range gives black with the flag
// clear. The pipeline has six register stages. The first stage captures the request
// at the edge that takes it, and the result then passes the chroma, mix, sum, product
// and output registers to m_tdata. One request is taken every clock cycle unless the
// output stalls. A stall on the output freezes every stage at once: s_tready follows
// only the output register's valid bit and m_tready.
module hsv_to_rgb_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // hue [9:0], saturation [16:10], brightness [23:17]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tuser    // in_range [0]
);
  import hsv_pkg::*;

  logic                        en;
  logic                        dec_valid;
  dec_t                        dec;
  logic                        mix_valid;
  mix_t                        mix;
  logic [NUM_CH-1:0][CH_W-1:0] rgb;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  hsv_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .hue        (s_tdata[HUE_W-1:0]),
    .saturation (s_tdata[HUE_W +: PCT_W]),
    .brightness (s_tdata[HUE_W + PCT_W +: PCT_W]),
    .out_valid  (dec_valid),
    .dec        (dec)
  );

  hsv_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dec_valid),
    .dec       (dec),
    .out_valid (mix_valid),
    .mix       (mix)
  );

  hsv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mix_valid),
    .mix       (mix),
    .out_valid (m_tvalid),
    .in_range  (m_tuser),
    .rgb       (rgb)
  );

  assign m_tdata = rgb;

endmodule

/* rtl/hsv_decode.sv */
module hsv_decode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [hsv_pkg::HUE_W-1:0]    hue,
  input  logic        [hsv_pkg::PCT_W-1:0]    saturation,
  input  logic        [hsv_pkg::PCT_W-1:0]    brightness,
  output logic                                out_valid,
  output hsv_pkg::dec_t                       dec
);
  import hsv_pkg::*;

  logic [HUE_W-2:0] hu;
  logic [HUE_W-2:0] base;
  logic [HUE_W-2:0] hm;
  dec_t             dec_next;

  always_comb begin
    hu = hue[HUE_W-2:0];
    dec_next.in_range = !hue[HUE_W-1] && (hu <= (HUE_W-1)'(HUE_MAX)) &&
                        (saturation <= PCT_W'(PCT_MAX)) && (brightness <= PCT_W'(PCT_MAX));
    if (hu < (HUE_W-1)'(SECTOR_DEG)) begin
      dec_next.sector = SECT_RY;
    end else if (hu < (HUE_W-1)'(2 * SECTOR_DEG)) begin
      dec_next.sector = SECT_YG;
    end else if (hu < (HUE_W-1)'(3 * SECTOR_DEG)) begin
      dec_next.sector = SECT_GC;
    end else if (hu < (HUE_W-1)'(4 * SECTOR_DEG)) begin
      dec_next.sector = SECT_CB;
    end else if (hu < (HUE_W-1)'(5 * SECTOR_DEG)) begin
      dec_next.sector = SECT_BM;
    end else begin
      dec_next.sector = SECT_MR;
    end
    if (hu < (HUE_W-1)'(2 * SECTOR_DEG)) begin
      base = '0;
    end else if (hu < (HUE_W-1)'(4 * SECTOR_DEG)) begin
      base = (HUE_W-1)'(2 * SECTOR_DEG);
    end else if (hu < (HUE_W-1)'(HUE_MAX)) begin
      base = (HUE_W-1)'(4 * SECTOR_DEG);
    end else begin
      base = (HUE_W-1)'(HUE_MAX);
    end
    hm = hu - base;
    if (hm < (HUE_W-1)'(SECTOR_DEG)) begin
      dec_next.weight = WT_W'(hm);
    end else begin
      dec_next.weight = WT_W'((HUE_W-1)'(2 * SECTOR_DEG) - hm);
    end
    dec_next.sat = saturation;
    dec_next.val = brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

/* rtl/hsv_chroma.sv */
module hsv_chroma (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  hsv_pkg::dec_t dec,
  output logic          out_valid,
  output hsv_pkg::mix_t mix
);
  import hsv_pkg::*;

  logic              valid2;
  logic              in_range2;
  logic [SECT_W-1:0] sector2;
  logic [WT_W-1:0]   weight2;
  logic [C_W-1:0]    chroma2;
  logic [C_W-1:0]    hundred_v2;
  mix_t              mix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid2 <= in_valid;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_range2 <= dec.in_range;
      sector2 <= dec.sector;
      weight2 <= dec.weight;
      chroma2 <= C_W'(dec.sat) * C_W'(dec.val);
      hundred_v2 <= C_W'(dec.val) * C_W'(PCT_MAX);
    end
  end

  always_comb begin
    mix_next.in_range = in_range2;
    mix_next.picks = picks_for(sector2);
    mix_next.c60 = SC_W'(chroma2) * SC_W'(SECTOR_DEG);
    mix_next.x60 = SC_W'(chroma2) * SC_W'(weight2);
    mix_next.m60 = SC_W'(hundred_v2 - chroma2) * SC_W'(SECTOR_DEG);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mix <= mix_next;
    end
  end

endmodule

/* rtl/hsv_scale.sv */
module hsv_scale (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  logic                                                    in_valid,
  input  hsv_pkg::mix_t                                           mix,
  output logic                                                    out_valid,
  output logic                                                    in_range,
  output logic [hsv_pkg::NUM_CH-1:0][hsv_pkg::CH_W-1:0]           rgb
);
  import hsv_pkg::*;

  logic                             valid4;
  logic                             valid5;
  logic                             range4;
  logic                             range5;
  logic [NUM_CH-1:0][SC_W-1:0]      sum_next;
  logic [NUM_CH-1:0][SC_W-1:0]      sum;
  logic [NUM_CH-1:0][T_W-1:0]       pre;
  logic [NUM_CH-1:0][PROD_W-1:0]    prod;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      case (mix.picks[i])
        PICK_C:  sum_next[i] = mix.c60 + mix.m60;
        PICK_X:  sum_next[i] = mix.x60 + mix.m60;
        default: sum_next[i] = mix.m60;
      endcase
      if (!mix.in_range) begin
        sum_next[i] = '0;
      end
      pre[i] = T_W'(((SC_W + 5)'(sum[i]) * (SC_W + 5)'(SCALE_MUL)) >> SCALE_PRE_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      valid5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid4 <= in_valid;
      valid5 <= valid4;
      out_valid <= valid5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range4 <= mix.in_range;
      range5 <= range4;
      in_range <= range5;
      for (int i = 0; i < NUM_CH; i++) begin
        sum[i] <= sum_next[i];
        prod[i] <= PROD_W'(pre[i]) * PROD_W'(RECIP);
        rgb[i] <= prod[i][RECIP_SHIFT +: CH_W];
      end
    end
  end

endmodule

/* rtl/hsv_checker.sv */
module hsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result present right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("Out-of-range request gave a nonblack color.");

  assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("Input ready does not follow the output stage.");

endmodule

bind hsv_to_rgb_core hsv_checker u_hsv_checker (.*);
